// ===== rtl/core/lcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared widths, register codes and pipeline payload types of the line clipper.
// ----------------------------------------------------------------------------
package lcr_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int T_BITS        = 28;
   localparam int CW            = 32;
   localparam int DW            = CW + 1;
   localparam int RW            = DW + 1;
   localparam int QW            = T_BITS + 1;
   localparam int FW            = T_BITS + 3;
   localparam int LANES         = 4;
   localparam int TL            = 14;
   localparam int TH            = QW - TL;
   localparam int PW            = DW + QW;
   localparam int RGW           = 15;
   localparam int AW            = 4;
   localparam int PDW           = 32;

   typedef enum logic [1:0] {
      REG_LEFT   = 2'd0,
      REG_TOP    = 2'd1,
      REG_RIGHT  = 2'd2,
      REG_BOTTOM = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] sz;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [DW-1:0] dz;
      logic                 empty;
      logic                 ok;
      logic                 zx;
      logic                 zy;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [DW-1:0] ad;
      logic [QW-1:0] q;
      logic          neg;
      logic          sat;
   } dlane_type;

endpackage

// ===== rtl/core/lcr_if.sv =====
// ----------------------------------------------------------------------------
// lcr_req_if / lcr_rsp_if
// Valid/ready channels for segment items and clipped result items.
// ----------------------------------------------------------------------------
interface lcr_req_if;
   import lcr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] start_x;
   logic signed [CW-1:0] start_y;
   logic signed [CW-1:0] start_z;
   logic signed [CW-1:0] end_x;
   logic signed [CW-1:0] end_y;
   logic signed [CW-1:0] end_z;
   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 output ready);
endinterface

interface lcr_rsp_if;
   import lcr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 visible;
   logic signed [CW-1:0] clip_start_x;
   logic signed [CW-1:0] clip_start_y;
   logic signed [CW-1:0] clip_start_z;
   logic signed [CW-1:0] clip_end_x;
   logic signed [CW-1:0] clip_end_y;
   logic signed [CW-1:0] clip_end_z;
   modport source (output valid, visible, clip_start_x, clip_start_y, clip_start_z,
                   clip_end_x, clip_end_y, clip_end_z, input ready);
   modport sink (input valid, visible, clip_start_x, clip_start_y, clip_start_z,
                 clip_end_x, clip_end_y, clip_end_z, output ready);
endinterface

// ===== rtl/core/lcr_div.sv =====
// ----------------------------------------------------------------------------
// lcr_div
// Four-lane pipelined restoring divider, one quotient bit per stage, with
// saturation and sign applied at the output.
// ----------------------------------------------------------------------------
module lcr_div (
   input  logic                                          clock,
   input  logic [lcr_pkg::QW-1:0]                        en,
   input  lcr_pkg::dlane_type [lcr_pkg::LANES-1:0]       din_lane,
   input  lcr_pkg::side_type                             din_side,
   output logic [lcr_pkg::LANES-1:0][lcr_pkg::FW-1:0]    dout_frac,
   output lcr_pkg::side_type                             dout_side
);
   import lcr_pkg::*;

   dlane_type [LANES-1:0] lane_ff [QW];
   side_type              side_ff [QW];

   for (genvar g = 0; g < QW; g++) begin : g_stage
      dlane_type [LANES-1:0] src;
      dlane_type [LANES-1:0] lane_in;
      side_type              side_in;

      if (g == 0) begin : g_first
         assign src     = din_lane;
         assign side_in = din_side;
      end else begin : g_next
         assign src     = lane_ff[g-1];
         assign side_in = side_ff[g-1];
      end

      always_comb begin
         logic [RW-1:0] t;
         logic          ge;
         for (int l = 0; l < LANES; l++) begin
            t  = (g == 0) ? src[l].rem : {src[l].rem[RW-2:0], 1'b0};
            ge = t >= RW'(src[l].ad);
            lane_in[l]     = src[l];
            lane_in[l].rem = ge ? t - RW'(src[l].ad) : t;
            lane_in[l].q   = {src[l].q[QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (en[g]) begin
            lane_ff[g] <= lane_in;
            side_ff[g] <= side_in;
         end
      end
   end

   always_comb begin
      logic [FW-2:0] m;
      for (int l = 0; l < LANES; l++) begin
         m = lane_ff[QW-1][l].sat ? (FW-1)'(1) << QW : (FW-1)'(lane_ff[QW-1][l].q);
         dout_frac[l] = lane_ff[QW-1][l].neg ? -{1'b0, m} : {1'b0, m};
      end
   end

   assign dout_side = side_ff[QW-1];

endmodule

// ===== rtl/core/line_clip_to_rectangle.sv =====
// ----------------------------------------------------------------------------
// line_clip_to_rectangle
// Structure: 38 register stages, the 29-stage divider plus nine stages of
// setup, fraction select and interpolation.
// Throughput: one item per cycle; each stage stalls only when full and blocked.
// Reset: synchronous, active high; clears valids and loads rectangle 0,0,4096,4096.
// ----------------------------------------------------------------------------
module line_clip_to_rectangle #(
   parameter int FRAC_BITS = lcr_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   lcr_req_if.sink                  req,
   lcr_rsp_if.source                rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [lcr_pkg::AW-1:0]   csr_paddr,
   input  logic [lcr_pkg::PDW-1:0]  csr_pwdata,
   output logic [lcr_pkg::PDW-1:0]  csr_prdata,
   output logic                     csr_pready
);
   import lcr_pkg::*;

   localparam int EW   = RGW + FRAC_BITS;
   localparam int NW   = (EW > CW - 1 ? EW : CW - 1) + 2;
   localparam int S_A  = 0;
   localparam int S_B  = 1;
   localparam int S_C  = 2;
   localparam int S_DV = 3;
   localparam int S_D  = S_DV + QW;
   localparam int S_E  = S_D + 1;
   localparam int S_F  = S_E + 1;
   localparam int S_G  = S_F + 1;
   localparam int S_H  = S_G + 1;
   localparam int S_J  = S_H + 1;
   localparam int NS   = S_J + 1;
   localparam logic signed [FW-1:0] T_ONE = FW'(1) << T_BITS;

   // csr
   logic [RGW-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic           csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= RGW'(4096);
         bottom_ff <= RGW'(4096);
      end else if (csr_wr) begin
         unique case (reg_index_type'(csr_paddr[3:2]))
            REG_LEFT:   left_ff   <= csr_pwdata[RGW-1:0];
            REG_TOP:    top_ff    <= csr_pwdata[RGW-1:0];
            REG_RIGHT:  right_ff  <= csr_pwdata[RGW-1:0];
            REG_BOTTOM: bottom_ff <= csr_pwdata[RGW-1:0];
            default:    left_ff   <= left_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_LEFT:   csr_prdata = PDW'(left_ff);
         REG_TOP:    csr_prdata = PDW'(top_ff);
         REG_RIGHT:  csr_prdata = PDW'(right_ff);
         REG_BOTTOM: csr_prdata = PDW'(bottom_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // stage control
   logic [NS-1:0] v_ff, v_in, en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      for (int k = 0; k < NS; k++) begin
         if (en[k]) begin
            v_in[k] = (k == 0) ? req.valid : v_ff[k-1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req.ready = en[S_A];

   // stage A: input capture
   logic signed [CW-1:0] a_s_ff [3];
   logic signed [CW-1:0] a_e_ff [3];

   always_ff @(posedge clock) begin
      if (en[S_A]) begin
         a_s_ff[0] <= req.start_x;
         a_s_ff[1] <= req.start_y;
         a_s_ff[2] <= req.start_z;
         a_e_ff[0] <= req.end_x;
         a_e_ff[1] <= req.end_y;
         a_e_ff[2] <= req.end_z;
      end
   end

   // stage B: edge offsets and deltas
   logic signed [NW-1:0] b_nlx_ff, b_nhx_ff, b_nly_ff, b_nhy_ff;
   logic signed [NW-1:0] b_nlx_in, b_nhx_in, b_nly_in, b_nhy_in;
   side_type             b_side_ff, b_side_in;

   always_comb begin
      logic signed [NW-1:0] lo_x, hi_x, lo_y, hi_y, sx, sy;
      lo_x = NW'(left_ff) << FRAC_BITS;
      hi_x = (NW'(right_ff) - NW'(1)) << FRAC_BITS;
      lo_y = NW'(top_ff) << FRAC_BITS;
      hi_y = (NW'(bottom_ff) - NW'(1)) << FRAC_BITS;
      sx   = NW'(a_s_ff[0]);
      sy   = NW'(a_s_ff[1]);
      b_nlx_in = lo_x - sx;
      b_nhx_in = hi_x - sx;
      b_nly_in = lo_y - sy;
      b_nhy_in = hi_y - sy;
      b_side_in.sx    = a_s_ff[0];
      b_side_in.sy    = a_s_ff[1];
      b_side_in.sz    = a_s_ff[2];
      b_side_in.dx    = DW'(a_e_ff[0]) - DW'(a_s_ff[0]);
      b_side_in.dy    = DW'(a_e_ff[1]) - DW'(a_s_ff[1]);
      b_side_in.dz    = DW'(a_e_ff[2]) - DW'(a_s_ff[2]);
      b_side_in.empty = (right_ff <= left_ff) || (bottom_ff <= top_ff);
      b_side_in.ok    = 1'b0;
      b_side_in.zx    = 1'b0;
      b_side_in.zy    = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en[S_B]) begin
         b_nlx_ff  <= b_nlx_in;
         b_nhx_ff  <= b_nhx_in;
         b_nly_ff  <= b_nly_in;
         b_nhy_ff  <= b_nhy_in;
         b_side_ff <= b_side_in;
      end
   end

   // stage C: magnitudes, saturation and zero-delta tests
   function automatic dlane_type make_lane(logic signed [NW-1:0] num,
                                           logic signed [DW-1:0] d);
      dlane_type      r;
      logic [NW-1:0]  an;
      logic [DW-1:0]  ad;
      an    = num[NW-1] ? NW'(-num) : NW'(num);
      ad    = d[DW-1] ? DW'(-d) : DW'(d);
      r.rem = RW'(an);
      r.ad  = ad;
      r.q   = '0;
      r.neg = num[NW-1] ^ d[DW-1];
      r.sat = (NW+1)'(an) >= (NW+1)'({ad, 1'b0});
      return r;
   endfunction

   dlane_type [LANES-1:0] c_lane_ff, c_lane_in;
   side_type              c_side_ff, c_side_in;

   always_comb begin
      logic inx, iny;
      inx = (b_nlx_ff <= 0) && (b_nhx_ff >= 0);
      iny = (b_nly_ff <= 0) && (b_nhy_ff >= 0);
      c_side_in    = b_side_ff;
      c_side_in.zx = b_side_ff.dx == '0;
      c_side_in.zy = b_side_ff.dy == '0;
      c_side_in.ok = !b_side_ff.empty && (!c_side_in.zx || inx) && (!c_side_in.zy || iny);
      c_lane_in[0] = make_lane(b_nlx_ff, b_side_ff.dx);
      c_lane_in[1] = make_lane(b_nhx_ff, b_side_ff.dx);
      c_lane_in[2] = make_lane(b_nly_ff, b_side_ff.dy);
      c_lane_in[3] = make_lane(b_nhy_ff, b_side_ff.dy);
   end

   always_ff @(posedge clock) begin
      if (en[S_C]) begin
         c_lane_ff <= c_lane_in;
         c_side_ff <= c_side_in;
      end
   end

   // divider stages
   logic [LANES-1:0][FW-1:0] dv_frac;
   side_type                 dv_side;

   lcr_div u_div (
      .clock     (clock),
      .en        (en[S_DV +: QW]),
      .din_lane  (c_lane_ff),
      .din_side  (c_side_ff),
      .dout_frac (dv_frac),
      .dout_side (dv_side)
   );

   // stage D: signed fractions
   logic [LANES-1:0][FW-1:0] d_frac_ff;
   side_type                 d_side_ff;

   always_ff @(posedge clock) begin
      if (en[S_D]) begin
         d_frac_ff <= dv_frac;
         d_side_ff <= dv_side;
      end
   end

   // stage E: order per axis
   logic signed [FW-1:0] e_xmin_ff, e_xmax_ff, e_ymin_ff, e_ymax_ff;
   logic signed [FW-1:0] e_xmin_in, e_xmax_in, e_ymin_in, e_ymax_in;
   side_type             e_side_ff;

   always_comb begin
      logic signed [FW-1:0] xl, xh, yl, yh;
      xl = $signed(d_frac_ff[0]);
      xh = $signed(d_frac_ff[1]);
      yl = $signed(d_frac_ff[2]);
      yh = $signed(d_frac_ff[3]);
      e_xmin_in = (xl > xh) ? xh : xl;
      e_xmax_in = (xl > xh) ? xl : xh;
      e_ymin_in = (yl > yh) ? yh : yl;
      e_ymax_in = (yl > yh) ? yl : yh;
   end

   always_ff @(posedge clock) begin
      if (en[S_E]) begin
         e_xmin_ff <= e_xmin_in;
         e_xmax_ff <= e_xmax_in;
         e_ymin_ff <= e_ymin_in;
         e_ymax_ff <= e_ymax_in;
         e_side_ff <= d_side_ff;
      end
   end

   // stage F: entry, exit and visibility
   logic [QW-1:0] f_te_ff, f_tx_ff, f_te_in, f_tx_in;
   logic          f_vis_ff, f_vis_in;
   logic [DW-1:0] f_dmag_ff [3];
   logic [DW-1:0] f_dmag_in [3];
   side_type      f_side_ff;

   always_comb begin
      logic signed [FW-1:0] ent, ext, xa, xb, ya, yb;
      xa  = e_side_ff.zx ? '0 : e_xmin_ff;
      ya  = e_side_ff.zy ? '0 : e_ymin_ff;
      xb  = e_side_ff.zx ? T_ONE : e_xmax_ff;
      yb  = e_side_ff.zy ? T_ONE : e_ymax_ff;
      ent = (xa > ya) ? xa : ya;
      ent = (ent > 0) ? ent : '0;
      ext = (xb < yb) ? xb : yb;
      ext = (ext < T_ONE) ? ext : T_ONE;
      f_vis_in = e_side_ff.ok && (ent <= ext);
      f_te_in  = ent[QW-1:0];
      f_tx_in  = ext[QW-1:0];
      f_dmag_in[0] = e_side_ff.dx[DW-1] ? DW'(-e_side_ff.dx) : DW'(e_side_ff.dx);
      f_dmag_in[1] = e_side_ff.dy[DW-1] ? DW'(-e_side_ff.dy) : DW'(e_side_ff.dy);
      f_dmag_in[2] = e_side_ff.dz[DW-1] ? DW'(-e_side_ff.dz) : DW'(e_side_ff.dz);
   end

   always_ff @(posedge clock) begin
      if (en[S_F]) begin
         f_te_ff   <= f_te_in;
         f_tx_ff   <= f_tx_in;
         f_vis_ff  <= f_vis_in;
         f_dmag_ff <= f_dmag_in;
         f_side_ff <= e_side_ff;
      end
   end

   // stage G: partial products
   logic [DW+TL-1:0] g_ple_ff [3];
   logic [DW+TH-1:0] g_phe_ff [3];
   logic [DW+TL-1:0] g_plx_ff [3];
   logic [DW+TH-1:0] g_phx_ff [3];
   logic             g_vis_ff;
   side_type         g_side_ff;

   always_ff @(posedge clock) begin
      if (en[S_G]) begin
         for (int i = 0; i < 3; i++) begin
            g_ple_ff[i] <= (DW+TL)'(f_dmag_ff[i]) * (DW+TL)'(f_te_ff[TL-1:0]);
            g_phe_ff[i] <= (DW+TH)'(f_dmag_ff[i]) * (DW+TH)'(f_te_ff[QW-1:TL]);
            g_plx_ff[i] <= (DW+TL)'(f_dmag_ff[i]) * (DW+TL)'(f_tx_ff[TL-1:0]);
            g_phx_ff[i] <= (DW+TH)'(f_dmag_ff[i]) * (DW+TH)'(f_tx_ff[QW-1:TL]);
         end
         g_vis_ff  <= f_vis_ff;
         g_side_ff <= f_side_ff;
      end
   end

   // stage H: sum and scale with floor rounding
   logic [DW-1:0] h_qe_ff [3];
   logic [DW-1:0] h_qx_ff [3];
   logic [DW-1:0] h_qe_in [3];
   logic [DW-1:0] h_qx_in [3];
   logic [2:0]    dneg;
   logic          h_vis_ff;
   side_type      h_side_ff;

   assign dneg = {g_side_ff.dz[DW-1], g_side_ff.dy[DW-1], g_side_ff.dx[DW-1]};

   always_comb begin
      logic [PW-1:0] pe, px;
      for (int i = 0; i < 3; i++) begin
         pe = (PW'(g_phe_ff[i]) << TL) + PW'(g_ple_ff[i]);
         px = (PW'(g_phx_ff[i]) << TL) + PW'(g_plx_ff[i]);
         if (dneg[i]) begin
            pe = pe + ((PW'(1) << T_BITS) - PW'(1));
            px = px + ((PW'(1) << T_BITS) - PW'(1));
         end
         h_qe_in[i] = pe[T_BITS +: DW];
         h_qx_in[i] = px[T_BITS +: DW];
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_H]) begin
         h_qe_ff   <= h_qe_in;
         h_qx_ff   <= h_qx_in;
         h_vis_ff  <= g_vis_ff;
         h_side_ff <= g_side_ff;
      end
   end

   // stage J: result register
   logic                 j_vis_ff;
   logic signed [CW-1:0] j_r0_ff [3];
   logic signed [CW-1:0] j_r1_ff [3];
   logic signed [CW-1:0] j_r0_in [3];
   logic signed [CW-1:0] j_r1_in [3];
   logic [2:0]           hneg;

   assign hneg = {h_side_ff.dz[DW-1], h_side_ff.dy[DW-1], h_side_ff.dx[DW-1]};

   always_comb begin
      logic signed [DW:0] s, d, qe, qx;
      for (int i = 0; i < 3; i++) begin
         unique case (i)
            0: begin
               s = (DW+1)'(h_side_ff.sx);
               d = (DW+1)'(h_side_ff.dx);
            end
            1: begin
               s = (DW+1)'(h_side_ff.sy);
               d = (DW+1)'(h_side_ff.dy);
            end
            default: begin
               s = (DW+1)'(h_side_ff.sz);
               d = (DW+1)'(h_side_ff.dz);
            end
         endcase
         qe = hneg[i] ? -$signed({1'b0, h_qe_ff[i]}) : $signed({1'b0, h_qe_ff[i]});
         qx = hneg[i] ? -$signed({1'b0, h_qx_ff[i]}) : $signed({1'b0, h_qx_ff[i]});
         if (h_vis_ff) begin
            j_r0_in[i] = CW'(s + qe);
            j_r1_in[i] = CW'(s + qx);
         end else begin
            j_r0_in[i] = CW'(s);
            j_r1_in[i] = CW'(s + d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_J]) begin
         j_vis_ff <= h_vis_ff;
         j_r0_ff  <= j_r0_in;
         j_r1_ff  <= j_r1_in;
      end
   end

   assign rsp.valid        = v_ff[S_J];
   assign rsp.visible      = j_vis_ff;
   assign rsp.clip_start_x = j_r0_ff[0];
   assign rsp.clip_start_y = j_r0_ff[1];
   assign rsp.clip_start_z = j_r0_ff[2];
   assign rsp.clip_end_x   = j_r1_ff[0];
   assign rsp.clip_end_y   = j_r1_ff[1];
   assign rsp.clip_end_z   = j_r1_ff[2];

`ifndef SYNTH
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> v_ff[S_A])
      else $error("accepted item not captured");

   a_vis_order: assert property (@(posedge clock) disable iff (reset)
      (v_ff[S_F] && f_vis_ff) |-> (f_te_ff <= f_tx_ff))
      else $error("visible item with entry past exit");

   a_empty_hidden: assert property (@(posedge clock) disable iff (reset)
      (v_ff[S_F] && f_side_ff.empty) |-> !f_vis_ff)
      else $error("empty rectangle produced a visible item");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v_ff[S_J] && !rsp.ready) |=> (v_ff[S_J] && $stable(j_vis_ff)))
      else $error("stalled result lost");
`endif

endmodule
